// ===== hdl/pcx_run_length_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// pcx run-length encoder assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef PCX_RUN_LENGTH_ENCODER_DEFINES_SVH
`define PCX_RUN_LENGTH_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PCX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcx rle check failed");

// next-cycle implication, disabled while in reset
`define PCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcx rle check failed");

`endif

// ===== hdl/pcx_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcx rle package
// types and constants shared by the run-length encoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package pcx_rle_pkg;

	localparam int PIX_W       = 8;
	localparam int RUN_W       = 6;
	localparam int MAX_RUN_DEF = 63;

	localparam logic [PIX_W-1:0] COUNT_BASE = 8'hC0;

	// pairs produced by one pixel
	localparam logic [1:0] PAIRS_NONE = 2'd0;
	localparam logic [1:0] PAIRS_ONE  = 2'd1;
	localparam logic [1:0] PAIRS_TWO  = 2'd2;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	typedef struct packed {
		logic [PIX_W-1:0] count_byte;
		logic [PIX_W-1:0] value_byte;
		logic             image_done;
		logic             burst_end;
	} pair_t;

	typedef struct packed {
		logic [1:0] n_pairs;
		pair_t      first;
		pair_t      second;
	} core_res_t;

endpackage

`default_nettype wire

// ===== hdl/pcx_rle_core.sv =====
// ----------------------------------------------------------------------------
// pcx rle core
// holds the open run and works out the pairs one pixel closes
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_core
	import pcx_rle_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [PIX_W-1:0] pixel_s1,
	input  wire logic             last_s1,
	input  wire logic             advance,
	output core_res_t             res
);

	localparam logic [RUN_W-1:0] MAX_RUN_L = RUN_W'(MAX_RUN);

	logic             run_open_q;
	logic [PIX_W-1:0] run_value_q;
	logic [RUN_W-1:0] run_length_q;

	logic             close_run;
	logic             extend;
	logic [PIX_W-1:0] new_value;
	logic [RUN_W-1:0] new_length;
	pair_t            closed_pair;
	pair_t            final_pair;

	always_comb begin
		close_run  = run_open_q && ((pixel_s1 != run_value_q) || (run_length_q >= MAX_RUN_L));
		extend     = run_open_q && !close_run;
		new_value  = extend ? run_value_q : pixel_s1;
		new_length = extend ? RUN_W'(run_length_q + 1'b1) : RUN_W'(1);

		closed_pair.count_byte = COUNT_BASE | {{(PIX_W-RUN_W){1'b0}}, run_length_q};
		closed_pair.value_byte = run_value_q;
		closed_pair.image_done = 1'b0;
		closed_pair.burst_end  = !last_s1;

		final_pair.count_byte  = COUNT_BASE | {{(PIX_W-RUN_W){1'b0}}, new_length};
		final_pair.value_byte  = new_value;
		final_pair.image_done  = 1'b1;
		final_pair.burst_end   = 1'b1;

		if (close_run && last_s1) begin
			res.n_pairs = PAIRS_TWO;
		end else if (close_run || last_s1) begin
			res.n_pairs = PAIRS_ONE;
		end else begin
			res.n_pairs = PAIRS_NONE;
		end
		res.first  = close_run ? closed_pair : final_pair;
		res.second = final_pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q   <= 1'b0;
			run_value_q  <= '0;
			run_length_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				run_open_q   <= 1'b0;
				run_value_q  <= '0;
				run_length_q <= '0;
			end else begin
				run_open_q   <= 1'b1;
				run_value_q  <= new_value;
				run_length_q <= new_length;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pcx_rle_outq.sv =====
// ----------------------------------------------------------------------------
// pcx rle output queue
// small pair queue taking up to two pairs a cycle and giving one
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_outq
	import pcx_rle_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [1:0]            push_n,
	input  wire pair_t                 push_first,
	input  wire pair_t                 push_second,
	input  wire logic                  pop,
	output logic                       head_valid,
	output pair_t                      head,
	output logic [OUTQ_CNT_W-1:0]      space
);

	pair_t                 entries_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign space      = OUTQ_CNT_W'(OUTQ_DEPTH) - count_q;
	assign do_pop     = pop && head_valid;

	// entries only change in free slots, so the head holds while stalled
	always_ff @(posedge clk) begin
		if (push_n != PAIRS_NONE) begin
			entries_q[wr_ptr_q] <= push_first;
		end
		if (push_n == PAIRS_TWO) begin
			entries_q[OUTQ_PTR_W'(wr_ptr_q + 1'b1)] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= OUTQ_PTR_W'(wr_ptr_q + push_n);
			if (do_pop) begin
				rd_ptr_q <= OUTQ_PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= OUTQ_CNT_W'(count_q + {1'b0, push_n} - {2'b0, do_pop});
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pcx_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// pcx run-length encoder
// Pixels (8-bit palette indices, raster order) come in on the in_valid /
// in_ready channel, last_pixel set on the final pixel of an image. Pairs go
// out on out_valid / out_ready: count_byte (0xC0 plus run length) and
// value_byte, image_done on the pair that closes the image and burst_end on
// the last pair caused by one pixel. Every run is sent as a pair, runs cross
// rows and are cut at MAX_RUN pixels.
// A pixel request lands in an input register, is encoded against the open
// run once the output queue has room for its pairs, and those pairs are
// written to the four-entry output queue, whose head is offered on out_valid.
// One pixel per cycle is taken while the queue has room for its pairs; the
// output port drains one pair per cycle while out_ready is high, so pixels
// that yield two pairs can fill the queue and hold back the input.
// Reset clears the open run and empties the queue. When out_ready is low
// the head pair holds, the queue fills and in_ready drops once the input
// register holds a pixel whose pairs do not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_run_length_encoder
	import pcx_rle_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PIX_W-1:0] pixel,
	input  wire logic             last_pixel,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [PIX_W-1:0]      count_byte,
	output logic [PIX_W-1:0]      value_byte,
	output logic                  image_done,
	output logic                  burst_end
);

	logic                  valid_s1;
	logic [PIX_W-1:0]      pixel_s1;
	logic                  last_s1;
	logic                  advance;
	core_res_t             res;
	logic [OUTQ_CNT_W-1:0] space;
	pair_t                 head;

	assign advance  = valid_s1 && ({1'b0, res.n_pairs} <= space);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pixel_s1 <= pixel;
			last_s1  <= last_pixel;
		end
	end

	pcx_rle_core #(
		.MAX_RUN (MAX_RUN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_s1 (pixel_s1),
		.last_s1  (last_s1),
		.advance  (advance),
		.res      (res)
	);

	pcx_rle_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (advance ? res.n_pairs : PAIRS_NONE),
		.push_first  (res.first),
		.push_second (res.second),
		.pop         (out_ready),
		.head_valid  (out_valid),
		.head        (head),
		.space       (space)
	);

	assign count_byte = head.count_byte;
	assign value_byte = head.value_byte;
	assign image_done = head.image_done;
	assign burst_end  = head.burst_end;

endmodule

`default_nettype wire

// ===== hdl/pcx_rle_checker.sv =====
// ----------------------------------------------------------------------------
// pcx rle checker
// port-level checks on the encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcx_run_length_encoder_defines.svh"

module pcx_rle_checker
	import pcx_rle_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [PIX_W-1:0] pixel,
	input wire logic             last_pixel,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] count_byte,
	input wire logic [PIX_W-1:0] value_byte,
	input wire logic             image_done,
	input wire logic             burst_end
);

	logic [2*PIX_W+1:0] out_payload;

	assign out_payload = {count_byte, value_byte, image_done, burst_end};

	// stalled pair holds
	`PCX_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

	// count byte carries a run length of at least one
	`PCX_ASSERT_NOW(a_count, clk, arst_n, out_valid, count_byte > COUNT_BASE)

	// closing pair of an image is always the last of its burst
	`PCX_ASSERT_NOW(a_done_end, clk, arst_n, out_valid && image_done, burst_end)

	// nothing comes out in the cycle right after reset
	`PCX_ASSERT_NOW(a_reset_idle, clk, arst_n, !$past(arst_n), !out_valid)

endmodule

bind pcx_run_length_encoder pcx_rle_checker u_pcx_rle_checker (.*);

`default_nettype wire

// ===== tb/pcx_run_length_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx run-length encoder testbench
// Feeds pixel streams through the encoder with random gaps on both sides and
// checks every count/value pair against a cycle-free model of the run state:
// single pixels, colour changes, runs cut at 63 pixels and image flushes.
// ----------------------------------------------------------------------------

module pcx_run_length_encoder_tb;
	import pcx_rle_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic             lst;
	} pixel_req_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [PIX_W-1:0] pixel = '0;
	logic             last_pixel = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [PIX_W-1:0] count_byte;
	logic [PIX_W-1:0] value_byte;
	logic             image_done;
	logic             burst_end;

	pixel_req_t pixels_todo[$];
	pair_t      pairs_due[$];
	int         errors = 0;
	int         pairs_seen = 0;

	// open run as the encoder should hold it
	logic             run_open = 1'b0;
	logic [PIX_W-1:0] run_value = '0;
	logic [RUN_W-1:0] run_len = '0;

	pcx_run_length_encoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.last_pixel (last_pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.count_byte (count_byte),
		.value_byte (value_byte),
		.image_done (image_done),
		.burst_end  (burst_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stretch of the run where neither side idles
	function automatic logic no_idle_window();
		return ($time >= 3000 && $time < 5400);
	endfunction

	task automatic queue_pixel(input logic [PIX_W-1:0] px, input logic lst);
		pixels_todo.push_back('{px: px, lst: lst});
	endtask

	// advance the run state by one pixel and queue the pairs it releases
	task automatic encode_pixel(input logic [PIX_W-1:0] px, input logic lst);
		pair_t out_pair[2];
		int    n;
		n = 0;
		if (run_open && (px != run_value || run_len >= MAX_RUN_DEF)) begin
			out_pair[n] = '{count_byte: COUNT_BASE + {2'b00, run_len},
				value_byte: run_value, image_done: 1'b0, burst_end: 1'b0};
			n++;
			run_open = 1'b0;
		end
		if (run_open) begin
			run_len = RUN_W'(run_len + 1'b1);
		end else begin
			run_open = 1'b1;
			run_value = px;
			run_len = RUN_W'(1);
		end
		if (lst) begin
			out_pair[n] = '{count_byte: COUNT_BASE + {2'b00, run_len},
				value_byte: run_value, image_done: 1'b1, burst_end: 1'b0};
			n++;
			run_open = 1'b0;
			run_value = '0;
			run_len = '0;
		end
		if (n > 0)
			out_pair[n-1].burst_end = 1'b1;
		for (int i = 0; i < n; i++)
			pairs_due.push_back(out_pair[i]);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel <= '0;
			last_pixel <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pixels_todo.size() != 0 && (no_idle_window() || $urandom_range(99) >= 16)) begin
				nxt = pixels_todo.pop_front();
				in_valid <= 1'b1;
				pixel <= nxt.px;
				last_pixel <= nxt.lst;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: predicts on accepted pixels, checks accepted pairs
	always @(posedge clk or negedge arst_n) begin
		pair_t seen;
		pair_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				encode_pixel(pixel, last_pixel);
			if (out_valid && out_ready) begin
				seen = {count_byte, value_byte, image_done, burst_end};
				if (pairs_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("pair %0d: none expected,", pairs_seen,
							" got count %h value %h done %b end %b",
							seen.count_byte, seen.value_byte, seen.image_done,
							seen.burst_end);
				end else begin
					want = pairs_due.pop_front();
					if (seen.count_byte !== want.count_byte
							|| seen.value_byte !== want.value_byte
							|| seen.image_done !== want.image_done
							|| seen.burst_end !== want.burst_end) begin
						errors++;
						if (errors <= 10)
							$display("pair %0d: expected count %h value %h done %b end %b,",
								pairs_seen, want.count_byte, want.value_byte,
								want.image_done, want.burst_end,
								" got count %h value %h done %b end %b",
								seen.count_byte, seen.value_byte, seen.image_done,
								seen.burst_end);
					end
				end
				pairs_seen++;
			end
			out_ready <= no_idle_window() || $urandom_range(99) >= 16;
		end
	end

	initial begin
		logic [PIX_W-1:0] v;
		int               runs;
		int               len;
		int               r;
		v = '0;

		// single-pixel images at both ends of the range
		queue_pixel(8'h00, 1'b1);
		queue_pixel(8'hFF, 1'b1);
		// values with the count marker bits set, run closed by a change,
		// final pixel extending the open run
		queue_pixel(8'hC0, 1'b0);
		queue_pixel(8'hC0, 1'b0);
		queue_pixel(8'h3F, 1'b0);
		queue_pixel(8'h3F, 1'b1);
		// last pixel differs from the open run: two pairs at once
		queue_pixel(8'hA5, 1'b0);
		queue_pixel(8'h5A, 1'b1);
		queue_pixel(8'h80, 1'b0);
		queue_pixel(8'h01, 1'b0);
		queue_pixel(8'h01, 1'b0);
		queue_pixel(8'h7F, 1'b0);
		queue_pixel(8'hFE, 1'b1);
		queue_pixel(8'hC1, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'hFF, 1'b1);

		// full runs: exactly 63 closed by the last pixel, 63 then the same
		// value again, 63 then a change
		v = PIX_W'($urandom);
		repeat (62) queue_pixel(v, 1'b0);
		queue_pixel(v, 1'b1);
		v = PIX_W'($urandom);
		repeat (63) queue_pixel(v, 1'b0);
		queue_pixel(v, 1'b1);
		v = PIX_W'($urandom);
		repeat (63) queue_pixel(v, 1'b0);
		queue_pixel(~v, 1'b1);

		while (pixels_todo.size() < 1450) begin
			if ($urandom_range(9) == 0) begin
				// noise: unrelated pixels, stray image ends
				repeat ($urandom_range(1, 12))
					queue_pixel(PIX_W'($urandom), $urandom_range(7) == 0);
			end else begin
				runs = $urandom_range(1, 6);
				for (int k = 0; k < runs; k++) begin
					if ($urandom_range(3) != 0)
						v = PIX_W'($urandom);
					r = $urandom_range(99);
					len = (r < 60) ? $urandom_range(1, 3) :
						(r < 85) ? $urandom_range(4, 12) : $urandom_range(55, 130);
					for (int j = 0; j < len; j++)
						queue_pixel(v, k == runs - 1 && j == len - 1);
				end
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixels_todo.size() != 0 || in_valid)
			@(negedge clk);
		while (pairs_due.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
